// File: hdl/wavhc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the WAV header checker.
// Used by the front parser, the verdict queue, the back end and the top level.
package wavhc_pkg;

  localparam logic [31:0] MAGIC_RIFF = 32'h4646_4952;
  localparam logic [31:0] MAGIC_WAVE = 32'h4556_4157;
  localparam logic [31:0] MAGIC_FMT  = 32'h2074_6d66;
  localparam logic [31:0] MAGIC_DATA = 32'h6174_6164;

  localparam logic [31:0] MIN_FILE    = 32'd44;
  localparam logic [31:0] FMT_LEN     = 32'd16;
  localparam logic [15:0] PCM_CODE    = 16'd1;
  localparam logic [31:0] RIFF_HDR    = 32'd8;
  localparam logic [31:0] MS_PER_S    = 32'd1000;
  localparam logic [31:0] SEARCH_FROM = 32'd36;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_SMALL    = 4'd1,
    ST_RIFF     = 4'd2,
    ST_WAVE     = 4'd3,
    ST_FILESIZE = 4'd4,
    ST_FMT      = 4'd5,
    ST_FMTSIZE  = 4'd6,
    ST_NOTPCM   = 4'd7,
    ST_BYTERATE = 4'd8,
    ST_ALIGN    = 4'd9,
    ST_NODATA   = 4'd10,
    ST_DATASIZE = 4'd11
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] sample_bits;
    logic [31:0] data_length;
    logic [31:0] data_start;
  } verdict_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: hdl/wavhc_front.sv
`timescale 1ns / 1ps
// Front parser: takes file bytes, holds the length register, runs the header checks
// and the data chunk search, and pushes one verdict word per file. Uses wavhc_pkg.
module wavhc_front import wavhc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  file_byte_i,
  input  logic        final_byte_i,
  input  q_stat_t     q_stat_i,
  output logic        push_o,
  output verdict_t    push_data_o
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_SEARCH,
    PH_SIZE
  } phase_e;

  localparam logic [31:0] OFS_RIFF  = 32'd3;
  localparam logic [31:0] OFS_RLEN  = 32'd7;
  localparam logic [31:0] OFS_WAVE  = 32'd11;
  localparam logic [31:0] OFS_FMT   = 32'd15;
  localparam logic [31:0] OFS_FLEN  = 32'd19;
  localparam logic [31:0] OFS_CODE  = 32'd21;
  localparam logic [31:0] OFS_CHAN  = 32'd23;
  localparam logic [31:0] OFS_RATE  = 32'd27;
  localparam logic [31:0] OFS_BRATE = 32'd31;
  localparam logic [31:0] OFS_ALIGN = 32'd33;
  localparam logic [31:0] OFS_BITS  = 32'd35;

  logic [31:0] len_q;
  logic [31:0] pos_q, pos_d;
  logic [31:0] tail_q, tail_d;
  phase_e      phase_q, phase_d;
  logic        done_q, done_d;
  logic [31:0] riff_q, riff_d;
  logic [15:0] ch_q, ch_d;
  logic [31:0] rate_q, rate_d;
  logic [31:0] br_q, br_d;
  logic [15:0] align_q, align_d;
  logic [15:0] bits_q, bits_d;
  logic [31:0] end_q, end_d;
  logic [31:0] start_q, start_d;
  logic [31:0] rc_q;

  logic        accept;
  logic [31:0] tail_nx;
  logic [15:0] low16;
  logic [31:0] prod_br;
  logic [31:0] prod_al;
  logic        emit;
  logic        ok;
  status_e     code;

  assign accept  = in_valid_i && !q_stat_i.full;
  assign in_stall_o = q_stat_i.full;
  assign tail_nx = {file_byte_i, tail_q[31:8]};
  assign low16   = tail_nx[31:16];
  assign prod_br = rc_q * {16'b0, low16};
  assign prod_al = {16'b0, ch_q} * {16'b0, low16};

  always_comb begin
    pos_d   = pos_q;
    tail_d  = tail_q;
    phase_d = phase_q;
    done_d  = done_q;
    riff_d  = riff_q;
    ch_d    = ch_q;
    rate_d  = rate_q;
    br_d    = br_q;
    align_d = align_q;
    bits_d  = bits_q;
    end_d   = end_q;
    start_d = start_q;
    emit    = 1'b0;
    ok      = 1'b0;
    code    = ST_OK;

    if (accept && !done_q) begin
      if (pos_q == 32'd0 && len_q < MIN_FILE) begin
        emit = 1'b1;
        code = ST_SMALL;
      end else begin
        if (pos_q < len_q) begin
          tail_d = tail_nx;
          unique case (phase_q)
            PH_HEADER: begin
              case (pos_q)
                OFS_RIFF: begin
                  if (tail_nx != MAGIC_RIFF) begin
                    emit = 1'b1;
                    code = ST_RIFF;
                  end
                end
                OFS_RLEN: riff_d = tail_nx;
                OFS_WAVE: begin
                  if (tail_nx != MAGIC_WAVE) begin
                    emit = 1'b1;
                    code = ST_WAVE;
                  end else if (riff_q != len_q - RIFF_HDR) begin
                    emit = 1'b1;
                    code = ST_FILESIZE;
                  end
                end
                OFS_FMT: begin
                  if (tail_nx != MAGIC_FMT) begin
                    emit = 1'b1;
                    code = ST_FMT;
                  end
                end
                OFS_FLEN: begin
                  if (tail_nx != FMT_LEN) begin
                    emit = 1'b1;
                    code = ST_FMTSIZE;
                  end
                end
                OFS_CODE: begin
                  if (low16 != PCM_CODE) begin
                    emit = 1'b1;
                    code = ST_NOTPCM;
                  end
                end
                OFS_CHAN:  ch_d = low16;
                OFS_RATE:  rate_d = tail_nx;
                OFS_BRATE: br_d = tail_nx;
                OFS_ALIGN: align_d = low16;
                OFS_BITS: begin
                  bits_d = low16;
                  if (br_q != {3'b0, prod_br[31:3]}) begin
                    emit = 1'b1;
                    code = ST_BYTERATE;
                  end else if ({16'b0, align_q} != {3'b0, prod_al[31:3]}) begin
                    emit = 1'b1;
                    code = ST_ALIGN;
                  end else begin
                    phase_d = PH_SEARCH;
                  end
                end
                default: ;
              endcase
            end
            PH_SEARCH: begin
              if (pos_q >= SEARCH_FROM + 32'd3 && tail_nx == MAGIC_DATA) begin
                phase_d = PH_SIZE;
                end_d   = pos_q + 32'd4;
                start_d = pos_q + 32'd5;
              end
            end
            PH_SIZE: begin
              if (pos_q == end_q) begin
                emit = 1'b1;
                if (tail_nx != len_q - start_q) begin
                  code = ST_DATASIZE;
                end else begin
                  ok   = 1'b1;
                  code = ST_OK;
                end
              end
            end
            default: ;
          endcase
        end
        if (!emit && (final_byte_i || pos_q + 32'd1 == len_q)) begin
          emit = 1'b1;
          unique case (phase_d)
            PH_HEADER: code = ST_SMALL;
            PH_SEARCH: code = ST_NODATA;
            default:   code = ST_DATASIZE;
          endcase
        end
      end
      if (emit) begin
        done_d = 1'b1;
      end
    end

    if (accept) begin
      if (final_byte_i) begin
        pos_d   = '0;
        tail_d  = '0;
        phase_d = PH_HEADER;
        done_d  = 1'b0;
        riff_d  = '0;
        ch_d    = '0;
        rate_d  = '0;
        br_d    = '0;
        align_d = '0;
        bits_d  = '0;
        end_d   = '0;
        start_d = '0;
      end else if (pos_q != '1) begin
        pos_d = pos_q + 32'd1;
      end
    end
  end

  always_comb begin
    push_o      = emit;
    push_data_o = '0;
    push_data_o.status = code;
    if (ok) begin
      push_data_o.channel_count = ch_q;
      push_data_o.sample_rate   = rate_q;
      push_data_o.byte_rate     = br_q;
      push_data_o.block_align   = align_q;
      push_data_o.sample_bits   = bits_q;
      push_data_o.data_length   = tail_nx;
      push_data_o.data_start    = start_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      pos_q   <= '0;
      tail_q  <= '0;
      phase_q <= PH_HEADER;
      done_q  <= 1'b0;
      riff_q  <= '0;
      ch_q    <= '0;
      rate_q  <= '0;
      br_q    <= '0;
      align_q <= '0;
      bits_q  <= '0;
      end_q   <= '0;
      start_q <= '0;
    end else begin
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
      pos_q   <= pos_d;
      tail_q  <= tail_d;
      phase_q <= phase_d;
      done_q  <= done_d;
      riff_q  <= riff_d;
      ch_q    <= ch_d;
      rate_q  <= rate_d;
      br_q    <= br_d;
      align_q <= align_d;
      bits_q  <= bits_d;
      end_q   <= end_d;
      start_q <= start_d;
    end
  end

  // rate * channels, settled long before the bits field arrives
  always_ff @(posedge clk_i) begin
    rc_q <= rate_q * {16'b0, ch_q};
  end

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !q_stat_i.full)
    else $error("verdict pushed into a full queue");

  a_phase_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_HEADER) |-> (pos_q >= SEARCH_FROM))
    else $error("left header phase before the fmt chunk ended");

endmodule

// File: hdl/wavhc_fifo.sv
`timescale 1ns / 1ps
// Short verdict queue between the front parser and the back end.
// Uses wavhc_pkg for the word type and depth.
module wavhc_fifo import wavhc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  verdict_t push_data_i,
  input  logic     pop_i,
  output verdict_t pop_data_o,
  output q_stat_t  stat_o
);

  verdict_t             mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_q;
  logic [Q_PTR_W-1:0]   rd_q;
  logic [Q_CNT_W-1:0]   cnt_q;
  logic                 do_push;
  logic                 do_pop;

  assign stat_o.full  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count beyond depth");

endmodule

// File: hdl/wavhc_back.sv
`timescale 1ns / 1ps
// Back end: pops verdict words, computes the duration (multiply by 1000, then a
// radix-2 restoring divide by the byte rate) and holds the result word. Uses wavhc_pkg.
module wavhc_back import wavhc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  q_stat_t  q_stat_i,
  input  verdict_t pop_data_i,
  output logic     pop_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output verdict_t res_o,
  output logic [31:0] duration_ms_o
);

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_DONE
  } bk_state_e;

  bk_state_e   state_q;
  verdict_t    ent_q;
  logic [31:0] num_q;
  logic [32:0] rem_q;
  logic [4:0]  cnt_q;
  logic [31:0] dur_q;
  logic        valid_q;

  logic [31:0] prod_ms;
  logic [32:0] rem_sh;
  logic        ge;
  logic [32:0] rem_nx;

  assign pop_o   = (state_q == BK_IDLE) && !q_stat_i.empty;
  assign prod_ms = ent_q.data_length * MS_PER_S;
  assign rem_sh  = {rem_q[31:0], num_q[31]};
  assign ge      = (rem_sh >= {1'b0, ent_q.byte_rate});
  assign rem_nx  = ge ? rem_sh - {1'b0, ent_q.byte_rate} : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      ent_q   <= '0;
      num_q   <= '0;
      rem_q   <= '0;
      cnt_q   <= '0;
      dur_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        BK_IDLE: begin
          if (!q_stat_i.empty) begin
            ent_q <= pop_data_i;
            if (pop_data_i.status == ST_OK && pop_data_i.byte_rate != '0) begin
              state_q <= BK_MUL;
            end else begin
              dur_q   <= '0;
              valid_q <= 1'b1;
              state_q <= BK_DONE;
            end
          end
        end
        BK_MUL: begin
          num_q   <= prod_ms;
          rem_q   <= '0;
          cnt_q   <= '0;
          state_q <= BK_DIV;
        end
        BK_DIV: begin
          rem_q <= rem_nx;
          num_q <= {num_q[30:0], ge};
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == '1) begin
            dur_q   <= {num_q[30:0], ge};
            valid_q <= 1'b1;
            state_q <= BK_DONE;
          end
        end
        BK_DONE: begin
          if (!out_stall_i) begin
            valid_q <= 1'b0;
            state_q <= BK_IDLE;
          end
        end
        default: state_q <= BK_IDLE;
      endcase
    end
  end

  assign out_valid_o   = valid_q;
  assign res_o         = ent_q;
  assign duration_ms_o = dur_q;

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_DIV) |-> (ent_q.byte_rate != '0 && ent_q.status == ST_OK))
    else $error("divide started without a valid divisor");

  a_valid_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q == (state_q == BK_DONE))
    else $error("result valid out of step with done state");

endmodule

// File: hdl/wav_header_checker_top.sv
`timescale 1ns / 1ps
// Top level of the WAV header checker: front parser, verdict queue, back end.
// Uses wavhc_pkg, wavhc_front, wavhc_fifo and wavhc_back.
//
//   channel | handshake             | payload
//   --------+-----------------------+--------------------------------------------
//   cfg     | cfg_we_i              | cfg_wdata_i (file length)
//   in      | in_valid_i/in_stall_o | file_byte_i, final_byte_i
//   out     | out_valid_o/out_stall_i | status_o .. duration_ms_o (one per file)
//
// Bytes are taken one per cycle; the input stalls only while the verdict queue
// (two words) is full. An error verdict or one with zero byte rate reaches the
// output in the cycle after it leaves the queue; a good verdict first passes a
// load, a multiply step and 32 divide steps of the serial divider.
// Reset clears the length register, the parser, the queue and the output.
module wav_header_checker_top import wavhc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  file_byte_i,
  input  logic        final_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  status_o,
  output logic [15:0] channel_count_o,
  output logic [31:0] sample_rate_o,
  output logic [31:0] byte_rate_o,
  output logic [15:0] block_align_o,
  output logic [15:0] sample_bits_o,
  output logic [31:0] data_length_o,
  output logic [31:0] data_start_o,
  output logic [31:0] duration_ms_o
);

  q_stat_t  q_stat;
  logic     push;
  verdict_t push_data;
  logic     pop;
  verdict_t pop_data;
  verdict_t res;

  wavhc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .file_byte_i  (file_byte_i),
    .final_byte_i (final_byte_i),
    .q_stat_i     (q_stat),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  wavhc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (q_stat)
  );

  wavhc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_stat_i      (q_stat),
    .pop_data_i    (pop_data),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .res_o         (res),
    .duration_ms_o (duration_ms_o)
  );

  assign status_o        = res.status;
  assign channel_count_o = res.channel_count;
  assign sample_rate_o   = res.sample_rate;
  assign byte_rate_o     = res.byte_rate;
  assign block_align_o   = res.block_align;
  assign sample_bits_o   = res.sample_bits;
  assign data_length_o   = res.data_length;
  assign data_start_o    = res.data_start;

endmodule
